// ===== rtl/dpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg
// shared types, constants and curve definitions for the dE/dx classifier
// ----------------------------------------------------------------------------
package dpc_pkg;

    // default fixed-point formats
    localparam int MOMENTUM_FRAC_BITS_DEF    = 12;
    localparam int ENERGY_LOSS_FRAC_BITS_DEF = 10;

    // field and register widths
    localparam int MOMENTUM_W    = 16;
    localparam int ENERGY_LOSS_W = 16;
    localparam int CLASS_W       = 2;
    localparam int REG_W         = 16;
    localparam int CFG_INDEX_W   = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PION_MIN_ENERGY_LOSS   = 3'd0,
        CFG_PION_MIN_MOMENTUM      = 3'd1,
        CFG_PION_MAX_MOMENTUM      = 3'd2,
        CFG_KAON_MIN_ENERGY_LOSS   = 3'd3,
        CFG_KAON_MAX_MOMENTUM      = 3'd4,
        CFG_PROTON_MIN_ENERGY_LOSS = 3'd5,
        CFG_PROTON_MAX_MOMENTUM    = 3'd6
    } cfg_index_t;

    // register reset values
    localparam logic [REG_W-1:0] PION_MIN_ENERGY_LOSS_RST   = 16'd205;
    localparam logic [REG_W-1:0] PION_MIN_MOMENTUM_RST      = 16'd614;
    localparam logic [REG_W-1:0] PION_MAX_MOMENTUM_RST      = 16'd4096;
    localparam logic [REG_W-1:0] KAON_MIN_ENERGY_LOSS_RST   = 16'd3277;
    localparam logic [REG_W-1:0] KAON_MAX_MOMENTUM_RST      = 16'd3686;
    localparam logic [REG_W-1:0] PROTON_MIN_ENERGY_LOSS_RST = 16'd3277;
    localparam logic [REG_W-1:0] PROTON_MAX_MOMENTUM_RST    = 16'd6554;

    // result codes
    typedef enum logic [CLASS_W-1:0] {
        CLASS_UNKNOWN = 2'd0,
        CLASS_PION    = 2'd1,
        CLASS_KAON    = 2'd2,
        CLASS_PROTON  = 2'd3
    } particle_class_t;

    // band curve a/(p-c)^2 + b, each coefficient as an exact ratio
    typedef struct packed {
        logic [7:0] a_num;
        logic [7:0] a_den;
        logic [7:0] b_num;
        logic [7:0] b_den;
        logic [7:0] c_num;
        logic [7:0] c_den;
    } curve_t;

    localparam curve_t PION_UPPER   = '{8'd29, 8'd100, 8'd22, 8'd10, 8'd0, 8'd1};
    localparam curve_t KAON_LOWER   = '{8'd3,  8'd10,  8'd22, 8'd10, 8'd0, 8'd1};
    localparam curve_t KAON_UPPER   = '{8'd7,  8'd10,  8'd25, 8'd10, 8'd1, 8'd20};
    localparam curve_t PROTON_LOWER = '{8'd9,  8'd10,  8'd25, 8'd10, 8'd1, 8'd20};
    localparam curve_t PROTON_UPPER = '{8'd24, 8'd10,  8'd3,  8'd1,  8'd3, 8'd20};

    // stage load enables handed to each curve unit
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    // side of the curve the energy loss falls on
    typedef struct packed {
        logic below;
        logic above;
    } side_t;

    // momentum and energy-loss window flags
    typedef struct packed {
        logic pion;
        logic kaon;
        logic proton;
    } window_t;

endpackage

// ===== rtl/dpc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_in_if
// track channel: momentum and energy loss with valid/ready handshake
// ----------------------------------------------------------------------------
interface dpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] momentum;
    logic [15:0] energy_loss;

    modport source (output valid, output momentum, output energy_loss, input ready);
    modport sink   (input valid, input momentum, input energy_loss, output ready);
endinterface

// ===== rtl/dpc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_out_if
// result channel: particle class with valid/ready handshake
// ----------------------------------------------------------------------------
interface dpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] particle_class;

    modport source (output valid, output particle_class, input ready);
    modport sink   (input valid, input particle_class, output ready);
endinterface

// ===== rtl/dpc_curve_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_curve_cmp
// three-stage compare of energy loss against one band curve, no division
// ----------------------------------------------------------------------------
module dpc_curve_cmp
    import dpc_pkg::*;
#(
    parameter int     MOMENTUM_FRAC_BITS    = MOMENTUM_FRAC_BITS_DEF,
    parameter int     ENERGY_LOSS_FRAC_BITS = ENERGY_LOSS_FRAC_BITS_DEF,
    parameter curve_t CURVE                 = PION_UPPER
)
(
    input  logic                     clk,
    input  pipe_en_t                 en,
    input  logic [MOMENTUM_W-1:0]    momentum,
    input  logic [ENERGY_LOSS_W-1:0] energy_loss,
    output side_t                    side
);

    localparam int MF = MOMENTUM_FRAC_BITS;
    localparam int EF = ENERGY_LOSS_FRAC_BITS;
    localparam int AF = EF + 2 * MF;

    // coefficient ratios in a wide constant context
    localparam logic [127:0] A_N = 128'(CURVE.a_num);
    localparam logic [127:0] A_D = 128'(CURVE.a_den);
    localparam logic [127:0] B_N = 128'(CURVE.b_num);
    localparam logic [127:0] B_D = 128'(CURVE.b_den);
    localparam logic [127:0] C_N = 128'(CURVE.c_num);
    localparam logic [127:0] C_D = 128'(CURVE.c_den);

    // round to nearest, ties up
    localparam logic [127:0] A_FIX = ((A_N / A_D) << AF) + ((((A_N % A_D) << AF) + A_D / 2) / A_D);
    localparam logic [127:0] B_FIX = ((B_N / B_D) << EF) + ((((B_N % B_D) << EF) + B_D / 2) / B_D);
    localparam logic [127:0] C_FIX = ((C_N / C_D) << MF) + ((((C_N % C_D) << MF) + C_D / 2) / C_D);

    localparam int DW   = (MF + 1 > MOMENTUM_W) ? MF + 1 : MOMENTUM_W;
    localparam int EW   = (EF + 2 > ENERGY_LOSS_W) ? EF + 2 : ENERGY_LOSS_W;
    localparam int SW   = 2 * DW;
    localparam int PW   = ENERGY_LOSS_W + SW;
    localparam int AW   = AF + 2;
    localparam int CMPW = (PW > AW) ? PW : AW;

    localparam logic [DW-1:0]   C_Q = C_FIX[DW-1:0];
    localparam logic [EW-1:0]   B_Q = B_FIX[EW-1:0];
    localparam logic [CMPW-1:0] A_Q = A_FIX[CMPW-1:0];

    logic [DW-1:0]            p_ext;
    logic [EW-1:0]            e_ext;
    logic [DW-1:0]            d_next;
    logic                     egt_next;
    logic [ENERGY_LOSS_W-1:0] eb_next;

    logic [DW-1:0]            d_reg;
    logic                     egt1_reg;
    logic [ENERGY_LOSS_W-1:0] eb1_reg;
    logic [SW-1:0]            dsq_reg;
    logic                     egt2_reg;
    logic [ENERGY_LOSS_W-1:0] eb2_reg;
    logic [PW-1:0]            prod_reg;
    logic                     egt3_reg;
    logic [CMPW-1:0]          prod_ext;

    // |p - c| and e - b
    always_comb
    begin
        p_ext    = DW'(momentum);
        e_ext    = EW'(energy_loss);
        d_next   = (p_ext >= C_Q) ? (p_ext - C_Q) : (C_Q - p_ext);
        egt_next = (e_ext > B_Q);
        eb_next  = ENERGY_LOSS_W'(e_ext - B_Q);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            d_reg    <= d_next;
            egt1_reg <= egt_next;
            eb1_reg  <= eb_next;
        end
        if (en.s2)
        begin
            dsq_reg  <= SW'(d_reg * d_reg);
            egt2_reg <= egt1_reg;
            eb2_reg  <= eb1_reg;
        end
        if (en.s3)
        begin
            prod_reg <= PW'(eb2_reg * dsq_reg);
            egt3_reg <= egt2_reg;
        end
    end

    // energy loss not above b, or p at c, counts as below
    always_comb
    begin
        prod_ext   = CMPW'(prod_reg);
        side.below = !egt3_reg || (prod_ext < A_Q);
        side.above = egt3_reg && (prod_ext > A_Q);
    end

endmodule

// ===== rtl/dedx_particle_classifier_unit.sv =====
`timescale 1ns / 1ps
// an accepted track passes stage registers 1, 2 and 3 before its result reaches the output register
// throughput: one track per cycle while result.ready is high; each stage holds its item only while the next is full
// the two multiplies per curve (square, then scale by energy loss) set the stage count
// reset: asynchronous active-low rst_n clears all valid bits and loads register defaults
// ----------------------------------------------------------------------------
// dedx_particle_classifier_unit
// classifies a track as pion, kaon or proton from momentum and dE/dx
// ----------------------------------------------------------------------------
module dedx_particle_classifier_unit
    import dpc_pkg::*;
#(
    parameter int MOMENTUM_FRAC_BITS    = MOMENTUM_FRAC_BITS_DEF,
    parameter int ENERGY_LOSS_FRAC_BITS = ENERGY_LOSS_FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    dpc_in_if.sink                 track,
    dpc_out_if.source              result,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]       cfg_data
);

    // configuration registers
    logic [REG_W-1:0] pion_min_energy_loss_reg;
    logic [REG_W-1:0] pion_min_momentum_reg;
    logic [REG_W-1:0] pion_max_momentum_reg;
    logic [REG_W-1:0] kaon_min_energy_loss_reg;
    logic [REG_W-1:0] kaon_max_momentum_reg;
    logic [REG_W-1:0] proton_min_energy_loss_reg;
    logic [REG_W-1:0] proton_max_momentum_reg;

    // stage valid bits; stage 4 is the output register
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;

    // a stage loads when it is empty or its content moves on
    logic     en1;
    logic     en2;
    logic     en3;
    logic     en4;
    pipe_en_t pipe_en;

    window_t win_next;
    window_t win1_reg;
    window_t win2_reg;
    window_t win3_reg;

    side_t pion_up;
    side_t kaon_lo;
    side_t kaon_up;
    side_t prot_lo;
    side_t prot_up;

    particle_class_t class_next;
    particle_class_t class_reg;

    // ------------------------------------------------------------------------
    // register writes, out-of-range index ignored
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pion_min_energy_loss_reg   <= PION_MIN_ENERGY_LOSS_RST;
            pion_min_momentum_reg      <= PION_MIN_MOMENTUM_RST;
            pion_max_momentum_reg      <= PION_MAX_MOMENTUM_RST;
            kaon_min_energy_loss_reg   <= KAON_MIN_ENERGY_LOSS_RST;
            kaon_max_momentum_reg      <= KAON_MAX_MOMENTUM_RST;
            proton_min_energy_loss_reg <= PROTON_MIN_ENERGY_LOSS_RST;
            proton_max_momentum_reg    <= PROTON_MAX_MOMENTUM_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PION_MIN_ENERGY_LOSS:   pion_min_energy_loss_reg   <= cfg_data;
                CFG_PION_MIN_MOMENTUM:      pion_min_momentum_reg      <= cfg_data;
                CFG_PION_MAX_MOMENTUM:      pion_max_momentum_reg      <= cfg_data;
                CFG_KAON_MIN_ENERGY_LOSS:   kaon_min_energy_loss_reg   <= cfg_data;
                CFG_KAON_MAX_MOMENTUM:      kaon_max_momentum_reg      <= cfg_data;
                CFG_PROTON_MIN_ENERGY_LOSS: proton_min_energy_loss_reg <= cfg_data;
                CFG_PROTON_MAX_MOMENTUM:    proton_max_momentum_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // flow control: ready ripples back from the output register
    // ------------------------------------------------------------------------
    always_comb
    begin
        en4         = !v4_reg || result.ready;
        en3         = !v3_reg || en4;
        en2         = !v2_reg || en3;
        en1         = !v1_reg || en2;
        track.ready = en1;
        pipe_en.s1  = en1;
        pipe_en.s2  = en2;
        pipe_en.s3  = en3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= track.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: momentum and energy-loss windows, all strict
    // ------------------------------------------------------------------------
    always_comb
    begin
        win_next.pion   = (track.momentum > pion_min_momentum_reg) &&
                          (track.momentum < pion_max_momentum_reg) &&
                          (track.energy_loss > pion_min_energy_loss_reg);
        win_next.kaon   = (track.momentum < kaon_max_momentum_reg) &&
                          (track.energy_loss > kaon_min_energy_loss_reg);
        win_next.proton = (track.momentum < proton_max_momentum_reg) &&
                          (track.energy_loss > proton_min_energy_loss_reg);
    end

    // window flags ride alongside the curve pipelines
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            win1_reg <= win_next;
        end
        if (en2)
        begin
            win2_reg <= win1_reg;
        end
        if (en3)
        begin
            win3_reg <= win2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // curve units, stages 1 to 3
    // ------------------------------------------------------------------------
    dpc_curve_cmp #(
        .MOMENTUM_FRAC_BITS    (MOMENTUM_FRAC_BITS),
        .ENERGY_LOSS_FRAC_BITS (ENERGY_LOSS_FRAC_BITS),
        .CURVE                 (PION_UPPER)
    ) u_pion_upper (
        .clk         (clk),
        .en          (pipe_en),
        .momentum    (track.momentum),
        .energy_loss (track.energy_loss),
        .side        (pion_up)
    );

    dpc_curve_cmp #(
        .MOMENTUM_FRAC_BITS    (MOMENTUM_FRAC_BITS),
        .ENERGY_LOSS_FRAC_BITS (ENERGY_LOSS_FRAC_BITS),
        .CURVE                 (KAON_LOWER)
    ) u_kaon_lower (
        .clk         (clk),
        .en          (pipe_en),
        .momentum    (track.momentum),
        .energy_loss (track.energy_loss),
        .side        (kaon_lo)
    );

    dpc_curve_cmp #(
        .MOMENTUM_FRAC_BITS    (MOMENTUM_FRAC_BITS),
        .ENERGY_LOSS_FRAC_BITS (ENERGY_LOSS_FRAC_BITS),
        .CURVE                 (KAON_UPPER)
    ) u_kaon_upper (
        .clk         (clk),
        .en          (pipe_en),
        .momentum    (track.momentum),
        .energy_loss (track.energy_loss),
        .side        (kaon_up)
    );

    dpc_curve_cmp #(
        .MOMENTUM_FRAC_BITS    (MOMENTUM_FRAC_BITS),
        .ENERGY_LOSS_FRAC_BITS (ENERGY_LOSS_FRAC_BITS),
        .CURVE                 (PROTON_LOWER)
    ) u_proton_lower (
        .clk         (clk),
        .en          (pipe_en),
        .momentum    (track.momentum),
        .energy_loss (track.energy_loss),
        .side        (prot_lo)
    );

    dpc_curve_cmp #(
        .MOMENTUM_FRAC_BITS    (MOMENTUM_FRAC_BITS),
        .ENERGY_LOSS_FRAC_BITS (ENERGY_LOSS_FRAC_BITS),
        .CURVE                 (PROTON_UPPER)
    ) u_proton_upper (
        .clk         (clk),
        .en          (pipe_en),
        .momentum    (track.momentum),
        .energy_loss (track.energy_loss),
        .side        (prot_up)
    );

    // ------------------------------------------------------------------------
    // stage 4: priority decision pion, kaon, proton
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (win3_reg.pion && pion_up.below)
        begin
            class_next = CLASS_PION;
        end
        else if (win3_reg.kaon && kaon_lo.above && kaon_up.below)
        begin
            class_next = CLASS_KAON;
        end
        else if (win3_reg.proton && prot_lo.above && prot_up.below)
        begin
            class_next = CLASS_PROTON;
        end
        else
        begin
            class_next = CLASS_UNKNOWN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            class_reg <= class_next;
        end
    end

    assign result.valid          = v4_reg;
    assign result.particle_class = class_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // input back-pressure only when every stage holds a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !track.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("track stalled with a free stage");

    // a result only appears after stage 3 held a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v4_reg) |-> $past(v3_reg))
        else $error("result valid without stage 3 transaction");

    // a stalled stage 3 transaction is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en3) |=> v3_reg)
        else $error("stage 3 transaction lost during stall");

    // neither lower band curve (kaon, proton) reports both sides at once
    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> !((kaon_lo.below && kaon_lo.above) || (prot_lo.below && prot_lo.above)))
        else $error("curve compare reports below and above");

endmodule

// ===== tb/dpc_class_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_class_checker
// watches the track and result channels, predicts the particle class of each
// accepted track and compares it with the class the classifier returns
// ----------------------------------------------------------------------------
module dpc_class_checker
    import dpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    dpc_in_if                      track,
    dpc_out_if                     result,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]       cfg_data,
    output int                     mismatch_count,
    output int                     pending_count
);

    localparam int MOM_FRAC     = MOMENTUM_FRAC_BITS_DEF;
    localparam int ELOSS_FRAC   = ENERGY_LOSS_FRAC_BITS_DEF;
    localparam int SCALE_FRAC   = ELOSS_FRAC + 2 * MOM_FRAC;
    localparam int REPORT_LIMIT = 10;

    typedef enum {
        CURVE_PION_UPPER,
        CURVE_KAON_LOWER,
        CURVE_KAON_UPPER,
        CURVE_PROTON_LOWER,
        CURVE_PROTON_UPPER
    } band_curve_e;

    typedef enum {SIDE_BELOW, SIDE_ON, SIDE_ABOVE} curve_side_e;

    typedef struct packed {
        logic [15:0]     momentum;
        logic [15:0]     energy_loss;
        particle_class_t particle_class;
    } track_class_t;

    // local copy of the cut registers
    logic [REG_W-1:0] pion_min_eloss;
    logic [REG_W-1:0] pion_min_mom;
    logic [REG_W-1:0] pion_max_mom;
    logic [REG_W-1:0] kaon_min_eloss;
    logic [REG_W-1:0] kaon_max_mom;
    logic [REG_W-1:0] proton_min_eloss;
    logic [REG_W-1:0] proton_max_mom;

    track_class_t expected_classes [$];

    // ratio num/den in fixed point, nearest with ties up
    function automatic longint unsigned round_fixed(input longint unsigned num,
                                                    input longint unsigned den,
                                                    input int frac);
        return ((num / den) << frac) + ((((num % den) << frac) + den / 2) / den);
    endfunction

    // where the energy loss falls against a/(p-c)^2 + b, without dividing
    function automatic curve_side_e side_of_curve(input band_curve_e curve_id,
                                                  input logic [15:0] p,
                                                  input logic [15:0] e);
        longint unsigned a_q;
        longint unsigned b_q;
        longint unsigned c_q;
        longint unsigned span;
        longint unsigned prod;
        case (curve_id)
            CURVE_PION_UPPER:
            begin
                a_q = round_fixed(29, 100, SCALE_FRAC);
                b_q = round_fixed(22, 10, ELOSS_FRAC);
                c_q = 0;
            end
            CURVE_KAON_LOWER:
            begin
                a_q = round_fixed(3, 10, SCALE_FRAC);
                b_q = round_fixed(22, 10, ELOSS_FRAC);
                c_q = 0;
            end
            CURVE_KAON_UPPER:
            begin
                a_q = round_fixed(7, 10, SCALE_FRAC);
                b_q = round_fixed(25, 10, ELOSS_FRAC);
                c_q = round_fixed(1, 20, MOM_FRAC);
            end
            CURVE_PROTON_LOWER:
            begin
                a_q = round_fixed(9, 10, SCALE_FRAC);
                b_q = round_fixed(25, 10, ELOSS_FRAC);
                c_q = round_fixed(1, 20, MOM_FRAC);
            end
            default:
            begin
                a_q = round_fixed(24, 10, SCALE_FRAC);
                b_q = round_fixed(3, 1, ELOSS_FRAC);
                c_q = round_fixed(3, 20, MOM_FRAC);
            end
        endcase
        if (e <= b_q)
            return SIDE_BELOW;
        span = (p >= c_q) ? (p - c_q) : (c_q - p);
        prod = (e - b_q) * (span * span);
        if (prod < a_q)
            return SIDE_BELOW;
        return (prod > a_q) ? SIDE_ABOVE : SIDE_ON;
    endfunction

    // pion first, then kaon, then proton; first match wins
    function automatic particle_class_t classify_track(input logic [15:0] p,
                                                       input logic [15:0] e);
        if (side_of_curve(CURVE_PION_UPPER, p, e) == SIDE_BELOW &&
            p < pion_max_mom && p > pion_min_mom && e > pion_min_eloss)
            return CLASS_PION;
        if (side_of_curve(CURVE_KAON_LOWER, p, e) == SIDE_ABOVE &&
            side_of_curve(CURVE_KAON_UPPER, p, e) == SIDE_BELOW &&
            p < kaon_max_mom && e > kaon_min_eloss)
            return CLASS_KAON;
        if (side_of_curve(CURVE_PROTON_LOWER, p, e) == SIDE_ABOVE &&
            side_of_curve(CURVE_PROTON_UPPER, p, e) == SIDE_BELOW &&
            p < proton_max_mom && e > proton_min_eloss)
            return CLASS_PROTON;
        return CLASS_UNKNOWN;
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        track_class_t entry;
        if (!rst_n)
        begin
            pion_min_eloss   = PION_MIN_ENERGY_LOSS_RST;
            pion_min_mom     = PION_MIN_MOMENTUM_RST;
            pion_max_mom     = PION_MAX_MOMENTUM_RST;
            kaon_min_eloss   = KAON_MIN_ENERGY_LOSS_RST;
            kaon_max_mom     = KAON_MAX_MOMENTUM_RST;
            proton_min_eloss = PROTON_MIN_ENERGY_LOSS_RST;
            proton_max_mom   = PROTON_MAX_MOMENTUM_RST;
            expected_classes.delete();
            pending_count = 0;
        end
        else
        begin
            // result transaction against the oldest prediction
            if (result.valid && result.ready)
            begin
                if (expected_classes.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result with no track pending, class %0d",
                                 $realtime, result.particle_class);
                    mismatch_count++;
                end
                else
                begin
                    entry = expected_classes.pop_front();
                    if (result.particle_class !== entry.particle_class)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: p %0d e %0d class expected %0d actual %0d",
                                     $realtime, entry.momentum, entry.energy_loss,
                                     entry.particle_class, result.particle_class);
                        mismatch_count++;
                    end
                end
            end
            if (track.valid && track.ready)
            begin
                entry.momentum       = track.momentum;
                entry.energy_loss    = track.energy_loss;
                entry.particle_class = classify_track(track.momentum, track.energy_loss);
                expected_classes.push_back(entry);
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_PION_MIN_ENERGY_LOSS:   pion_min_eloss   = cfg_data;
                    CFG_PION_MIN_MOMENTUM:      pion_min_mom     = cfg_data;
                    CFG_PION_MAX_MOMENTUM:      pion_max_mom     = cfg_data;
                    CFG_KAON_MIN_ENERGY_LOSS:   kaon_min_eloss   = cfg_data;
                    CFG_KAON_MAX_MOMENTUM:      kaon_max_mom     = cfg_data;
                    CFG_PROTON_MIN_ENERGY_LOSS: proton_min_eloss = cfg_data;
                    CFG_PROTON_MAX_MOMENTUM:    proton_max_mom   = cfg_data;
                    default: ;
                endcase
            end
            pending_count = expected_classes.size();
        end
    end

endmodule

// ===== tb/tb_dedx_particle_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedx_particle_classifier_unit
// drives tracks through the classifier under several cut settings, with
// random gaps on the track side and random stalls on the result side;
// the class checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_dedx_particle_classifier_unit;
    import dpc_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 175;
    localparam int MAX_WAIT      = 18;
    localparam int RESET_CYCLES  = 11;

    // an index the block has no register for
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 3'd7;

    // how a phase sets the cut registers
    typedef enum {
        CUTS_DEFAULT,
        CUTS_ZERO,
        CUTS_FULL,
        CUTS_WIDE,
        CUTS_SCALED,
        CUTS_RANDOM
    } cut_mode_e;

    // band curve coefficients in the block's fixed-point formats
    typedef struct {
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
    } curve_coef_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [REG_W-1:0]       cfg_data;
    int                     mismatch_count;
    int                     pending_count;

    // stretches with no idling, toggled now and then on each side
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;

    // what the cut registers hold now, used to aim the stimulus
    logic [REG_W-1:0] cut_val [0:6];

    dpc_in_if  track_if ();
    dpc_out_if result_if ();

    dedx_particle_classifier_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .track        (track_if),
        .result       (result_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    dpc_class_checker class_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .track          (track_if),
        .result         (result_if),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] clamp16(input longint v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return 16'(v);
    endfunction

    // anchor plus or minus a few codes, kept in range
    function automatic logic [15:0] jitter(input logic [15:0] anchor, input int spread);
        return clamp16(longint'(anchor) + longint'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic [REG_W-1:0] reset_cut(input cfg_index_t idx);
        case (idx)
            CFG_PION_MIN_ENERGY_LOSS:   return PION_MIN_ENERGY_LOSS_RST;
            CFG_PION_MIN_MOMENTUM:      return PION_MIN_MOMENTUM_RST;
            CFG_PION_MAX_MOMENTUM:      return PION_MAX_MOMENTUM_RST;
            CFG_KAON_MIN_ENERGY_LOSS:   return KAON_MIN_ENERGY_LOSS_RST;
            CFG_KAON_MAX_MOMENTUM:      return KAON_MAX_MOMENTUM_RST;
            CFG_PROTON_MIN_ENERGY_LOSS: return PROTON_MIN_ENERGY_LOSS_RST;
            default:                    return PROTON_MAX_MOMENTUM_RST;
        endcase
    endfunction

    // 0 pion upper, 1 kaon lower, 2 kaon upper, 3 proton lower, 4 proton upper
    function automatic curve_coef_t curve_coef(input int k);
        curve_coef_t cc;
        case (k)
            0:       cc = '{64'd4982162063,  64'd2253, 64'd0};
            1:       cc = '{64'd5153960755,  64'd2253, 64'd0};
            2:       cc = '{64'd12025908429, 64'd2560, 64'd205};
            3:       cc = '{64'd15461882266, 64'd2560, 64'd205};
            default: cc = '{64'd41231686042, 64'd3072, 64'd614};
        endcase
        return cc;
    endfunction

    // energy loss on curve k at momentum p, saturated; infinite at p = c
    function automatic logic [15:0] curve_energy(input int k, input logic [15:0] p);
        curve_coef_t     cc;
        longint unsigned span;
        cc   = curve_coef(k);
        span = (p >= cc.c) ? (p - cc.c) : (cc.c - p);
        if (span == 0)
            return 16'hFFFF;
        return clamp16(longint'(cc.b + cc.a / (span * span)));
    endfunction

    // momentum: mostly the low range where the bands live, some near cuts
    function automatic logic [15:0] pick_momentum();
        logic [15:0] anchor;
        curve_coef_t cc;
        case ($urandom_range(0, 9))
            0, 1:       return 16'($urandom);
            2, 3, 4, 5: return 16'($urandom_range(0, 8191));
            6, 7:       return 16'($urandom_range(0, 2047));
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       anchor = cut_val[CFG_PION_MIN_MOMENTUM];
                    1:       anchor = cut_val[CFG_PION_MAX_MOMENTUM];
                    2:       anchor = cut_val[CFG_KAON_MAX_MOMENTUM];
                    default: anchor = cut_val[CFG_PROTON_MAX_MOMENTUM];
                endcase
                return jitter(anchor, 3);
            end
            default:
            begin
                // close to a curve pole
                cc     = curve_coef($urandom_range(0, 4));
                anchor = 16'(cc.c);
                return jitter(anchor, 3);
            end
        endcase
    endfunction

    // energy loss: near a curve, inside a band, near an energy-loss cut or noise
    function automatic logic [15:0] pick_energy(input logic [15:0] p);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] swap;
        logic [15:0] anchor;
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2, 3, 4: return jitter(curve_energy($urandom_range(0, 4), p), 4);
            5, 6, 7:
            begin
                lo = curve_energy($urandom_range(0, 4), p);
                hi = curve_energy($urandom_range(0, 4), p);
                if (lo > hi)
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                return 16'($urandom_range(lo, hi));
            end
            8:
            begin
                case ($urandom_range(0, 2))
                    0:       anchor = cut_val[CFG_PION_MIN_ENERGY_LOSS];
                    1:       anchor = cut_val[CFG_KAON_MIN_ENERGY_LOSS];
                    default: anchor = cut_val[CFG_PROTON_MIN_ENERGY_LOSS];
                endcase
                return jitter(anchor, 3);
            end
            default: return 16'($urandom_range(0, 16383));
        endcase
    endfunction

    // one track transaction; valid stays high when the next comes with no gap
    task automatic push_track(input logic [15:0] p, input logic [15:0] e);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            track_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        track_if.valid       <= 1'b1;
        track_if.momentum    <= p;
        track_if.energy_loss <= e;
        @(posedge clk);
        while (!track_if.ready)
            @(posedge clk);
    endtask

    // write enable is left high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [REG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
    endtask

    task automatic configure(input cut_mode_e mode);
        cfg_index_t idx;
        for (int i = 0; i <= int'(CFG_PROTON_MAX_MOMENTUM); i++)
        begin
            idx = cfg_index_t'(i);
            case (mode)
                CUTS_DEFAULT: cut_val[idx] = reset_cut(idx);
                CUTS_ZERO:    cut_val[idx] = '0;
                CUTS_FULL:    cut_val[idx] = '1;
                CUTS_WIDE:
                    // widest windows: minimums at zero, maximums at full scale
                    cut_val[idx] = (idx == CFG_PION_MAX_MOMENTUM ||
                                    idx == CFG_KAON_MAX_MOMENTUM ||
                                    idx == CFG_PROTON_MAX_MOMENTUM) ? '1 : '0;
                CUTS_SCALED:
                    cut_val[idx] = clamp16(longint'(reset_cut(idx)) *
                                           longint'($urandom_range(50, 150)) / 100);
                default:      cut_val[idx] = 16'($urandom);
            endcase
            write_reg(idx, cut_val[idx]);
        end
        cfg_write_en <= 1'b0;
    endtask

    // stop sending and let every pending class come out
    task automatic wind_down();
        track_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        logic [15:0] p;
        repeat (count)
        begin
            p = pick_momentum();
            push_track(p, pick_energy(p));
        end
    endtask

    // result side: a random stall before each result transaction
    initial
    begin
        int stall;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
                @(posedge clk);
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0] e_edge;
        rst_n                <= 1'b0;
        cfg_write_en         <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        track_if.valid       <= 1'b0;
        track_if.momentum    <= '0;
        track_if.energy_loss <= '0;
        for (int i = 0; i <= int'(CFG_PROTON_MAX_MOMENTUM); i++)
            cut_val[i] = reset_cut(cfg_index_t'(i));
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed tracks at the reset cuts
        // field corners
        push_track(16'h0000, 16'h0000);
        push_track(16'hFFFF, 16'hFFFF);
        push_track(16'h0000, 16'hFFFF);
        push_track(16'hFFFF, 16'h0000);
        // one clear member of each band
        push_track(16'd2048, 16'd1024);
        push_track(16'd2048, 16'd4608);
        push_track(16'd3277, 16'd6144);
        // energy loss exactly at a curve offset b
        push_track(16'd2048, 16'd2253);
        // momentum on a curve pole, with and without energy loss at b
        push_track(16'd205, 16'd2560);
        push_track(16'd0, 16'd10000);
        push_track(16'd205, 16'd8000);
        push_track(16'd614, 16'd10000);
        // strict momentum cuts
        push_track(16'd614, 16'd1024);
        push_track(16'd615, 16'd1024);
        push_track(16'd4095, 16'd1024);
        push_track(16'd4096, 16'd1024);
        push_track(16'd3685, 16'd3500);
        push_track(16'd3686, 16'd3500);
        push_track(16'd6553, 16'd4000);
        push_track(16'd6554, 16'd4000);
        // strict energy-loss cuts
        push_track(16'd2048, 16'd205);
        push_track(16'd2048, 16'd206);
        push_track(16'd3600, 16'd3277);
        push_track(16'd3600, 16'd3278);
        // on the pion upper curve (rounded down) and one code above it
        e_edge = curve_energy(0, 16'd2048);
        push_track(16'd2048, e_edge);
        push_track(16'd2048, e_edge + 16'd1);

        run_random(PHASE_ITEMS);
        wind_down();

        // extremes of the cut registers
        configure(CUTS_ZERO);
        run_random(PHASE_ITEMS);
        wind_down();
        configure(CUTS_FULL);
        run_random(PHASE_ITEMS);
        wind_down();
        configure(CUTS_WIDE);
        run_random(PHASE_ITEMS);
        wind_down();

        // settings spread around the defaults, and fully random ones
        configure(CUTS_SCALED);
        run_random(PHASE_ITEMS);
        wind_down();
        configure(CUTS_RANDOM);
        run_random(PHASE_ITEMS);
        wind_down();

        // a write to an index with no register must change nothing
        write_reg(CFG_INDEX_UNUSED, 16'($urandom));
        configure(CUTS_DEFAULT);
        run_random(PHASE_ITEMS);
        wind_down();
        configure(CUTS_SCALED);
        run_random(PHASE_ITEMS);
        wind_down();

        if (mismatch_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dpc_pkg.sv
rtl/dpc_in_if.sv
rtl/dpc_out_if.sv
rtl/dpc_curve_cmp.sv
rtl/dedx_particle_classifier_unit.sv
tb/dpc_class_checker.sv
tb/tb_dedx_particle_classifier_unit.sv
